>>> src/pdh_pkg.sv
// Package for the pair distance histogram: operation codes, register indices and the shared word type.
`timescale 1ns / 1ps
package pdh_pkg;

    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_END   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [2:0] REG_BOX_X   = 3'd0;
    localparam logic [2:0] REG_BOX_Y   = 3'd1;
    localparam logic [2:0] REG_BOX_Z   = 3'd2;
    localparam logic [2:0] REG_MAX     = 3'd3;
    localparam logic [2:0] REG_BIN_W   = 3'd4;

    typedef logic [31:0] t_word;

endpackage

>>> src/pair_distance_histogram.sv
// Pair distance histogram top level: minimum image, distance, binning, bin store.
// Every operation passes through difference, wrap, square/sum, root, divide and bin
// read/update, in that order; the divide ends early at zero bin width. The input is not
// ready while an item is at work or a result waits.
// Reset: synchronous active low; then a clearing pass, one bin at a time, no stream input.
`timescale 1ns / 1ps
module pair_distance_histogram #(
    parameter int BIN_COUNT = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // tdata: operation[1:0], first_x, first_y, first_z, second_x, second_y,
    // second_z, read_index (from bit 0 up), zero fill to 208 bits
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [207:0] s_axis_tdata,
    // tuser: same_particle
    input  logic         s_axis_tuser,
    // tdata: bin_hit[7:0], bin_value[39:8], samples_taken[71:40]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata,
    // tuser: counted
    output logic         m_axis_tuser
);
    import pdh_pkg::*;

    localparam int BW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_DIFF  = 11'b00000000100,
        S_WRAP  = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_SQRT  = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_RD    = 11'b00010000000,
        S_RDW   = 11'b00100000000,
        S_WR    = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    t_word r_box_x, r_box_y, r_box_z, r_max, r_binw;
    t_word r_samples;

    // captured item
    logic [1:0]  r_op;
    logic        r_same;
    logic [7:0]  r_ridx;
    t_word       r_a [3];
    t_word       r_b [3];
    logic [32:0] r_m [3];     // per-axis magnitudes
    logic [1:0]  r_axis;

    // square root / divide registers
    logic [67:0] r_sum;
    logic [35:0] r_rem;
    logic [33:0] r_root;
    logic [5:0]  r_cnt;
    logic [32:0] r_drem;
    logic [31:0] r_quot;
    logic [63:0] r_prod;

    logic [BW-1:0] r_bin;
    logic          r_cnted;
    t_word         r_val;

    // bin memory
    t_word   mem [BIN_COUNT];
    t_word   r_rdata;
    logic [BW:0] r_clr;

    // output register
    logic        r_ovalid;
    logic [71:0] r_odata;
    logic        r_ouser;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready   = (r_state == S_IDLE) || (r_state == S_CLEAR);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

    // root and divide trial compares, and per-axis box length and magnitude selection
    logic [35:0] trial;
    logic        sq_ok;
    logic [35:0] rem_sh;
    logic [32:0] drem_sh;
    logic        dv_ok;
    logic [32:0] magd, twom;
    logic [32:0] axl;
    always_comb begin
        rem_sh  = {r_rem[33:0], r_sum[67:66]};
        trial   = {r_root, 2'b01};
        sq_ok   = rem_sh >= trial;
        drem_sh = {r_drem[31:0], r_quot[31]};
        dv_ok   = drem_sh >= {1'b0, r_binw};
        case (r_axis)
            2'd0:    axl = {1'b0, r_box_x};
            2'd1:    axl = {1'b0, r_box_y};
            default: axl = {1'b0, r_box_z};
        endcase
        case (r_axis)
            2'd0:    magd = r_m[0];
            2'd1:    magd = r_m[1];
            default: magd = r_m[2];
        endcase
        twom = {magd[31:0], 1'b0};
    end

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;

    logic drop;
    assign drop = (r_root[31:0] > r_max) || (r_root[33:32] != 2'b00)
                  || ((r_root[31:0] == r_max) && (r_rem != '0));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == (BW+1)'(BIN_COUNT - 1)) n_state = S_IDLE;
            S_IDLE:  if (accept) n_state = S_DIFF;
            S_DIFF:  n_state = S_WRAP;
            S_WRAP:  if (r_axis == 2'd2) n_state = S_MUL;
            S_MUL:   if (r_axis == 2'd3) n_state = S_SQRT;
            S_SQRT:  if (r_cnt == 6'd33) n_state = S_DIV;
            S_DIV:   if (r_cnt == 6'd31 || r_binw == '0) n_state = S_RD;
            S_RD:    n_state = S_RDW;
            S_RDW:   n_state = S_WR;
            S_WR:    n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // bin memory: clearing pass, read and write back of the updated count
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) mem[r_clr[BW-1:0]] <= '0;
        else if (r_state == S_OUT && r_op == OP_ACCUM && r_cnted) mem[r_bin] <= r_val;
        r_rdata <= mem[r_bin];
    end

    logic [31:0] q_full;
    assign q_full = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_box_x   <= 32'hFFFF_FFFF;
            r_box_y   <= 32'hFFFF_FFFF;
            r_box_z   <= 32'hFFFF_FFFF;
            r_max     <= 32'd65536;
            r_binw    <= 32'd256;
            r_samples <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_BOX_X: r_box_x <= i_cfg_data;
                    REG_BOX_Y: r_box_y <= i_cfg_data;
                    REG_BOX_Z: r_box_z <= i_cfg_data;
                    REG_MAX:   r_max   <= i_cfg_data;
                    REG_BIN_W: r_binw  <= i_cfg_data;
                    default:   ;
                endcase
            end
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            if (r_state == S_OUT) begin
                r_ovalid <= 1'b1;
                if (r_op == OP_END && r_samples != 32'hFFFF_FFFF) begin
                    r_samples <= r_samples + 1'b1;
                    r_odata   <= {r_samples + 32'd1, 32'd0, 8'd0};
                end else begin
                    r_odata <= {r_samples, r_val, r_op == OP_READ ? r_ridx :
                                (r_cnted ? 8'(r_bin) : 8'd0)};
                end
                r_ouser <= r_cnted;
            end
        end
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (accept) begin
                r_op   <= s_axis_tdata[1:0];
                r_a[0] <= s_axis_tdata[33:2];
                r_a[1] <= s_axis_tdata[65:34];
                r_a[2] <= s_axis_tdata[97:66];
                r_b[0] <= s_axis_tdata[129:98];
                r_b[1] <= s_axis_tdata[161:130];
                r_b[2] <= s_axis_tdata[193:162];
                r_ridx <= s_axis_tdata[201:194];
                r_same <= s_axis_tuser;
                r_axis <= 2'd0;
            end
            S_DIFF: begin
                for (int k = 0; k < 3; k++)
                    r_m[k] <= (r_a[k] >= r_b[k]) ? {1'b0, r_a[k] - r_b[k]}
                                                 : {1'b0, r_b[k] - r_a[k]};
                r_axis <= 2'd0;
            end
            S_WRAP: begin
                if (twom > axl)
                    r_m[r_axis] <= (magd >= axl) ? magd - axl : axl - magd;
                r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                r_sum  <= '0;
            end
            S_MUL: begin
                // one 32x32 multiply a cycle, its product added to the sum in the next cycle
                if (r_axis != 2'd3) r_prod <= r_m[r_axis][31:0] * r_m[r_axis][31:0];
                if (r_axis != 2'd0) r_sum <= r_sum + {4'd0, r_prod};
                r_axis <= r_axis + 2'd1;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
            end
            S_SQRT: begin
                r_rem  <= sq_ok ? rem_sh - trial : rem_sh;
                r_root <= {r_root[32:0], sq_ok};
                r_sum  <= {r_sum[65:0], 2'b00};
                r_cnt  <= (r_cnt == 6'd33) ? 6'd0 : r_cnt + 6'd1;
                r_quot <= {r_root[30:0], sq_ok};
                r_drem <= '0;
            end
            S_DIV: begin
                r_drem <= dv_ok ? drem_sh - {1'b0, r_binw} : drem_sh;
                r_quot <= {r_quot[30:0], dv_ok};
                r_cnt  <= r_cnt + 6'd1;
                r_cnted <= (r_op == OP_ACCUM) && !r_same && !drop;
                if (r_binw == '0) r_quot <= 32'hFFFF_FFFF;
            end
            S_RD: begin
                if (r_op == OP_READ) begin
                    r_bin   <= BW'(r_ridx);
                    r_cnted <= 1'b0;
                end else if (q_full > 32'(BIN_COUNT - 1)) r_bin <= BW'(BIN_COUNT - 1);
                else r_bin <= q_full[BW-1:0];
            end
            S_RDW: ;
            S_WR: begin
                if (r_op == OP_ACCUM && r_cnted)
                    r_val <= (r_rdata == 32'hFFFF_FFFF) ? r_rdata : r_rdata + 1'b1;
                else if (r_op == OP_READ && 32'(r_ridx) < 32'(BIN_COUNT))
                    r_val <= r_rdata;
                else r_val <= '0;
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("accept while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_counted_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_cnted) |-> r_op == OP_ACCUM)
        else $error("count on wrong operation");
`endif
endmodule

>>> bench/pair_distance_histogram_tb.sv
// Testbench for the pair distance histogram: directed table, then random pairs checked by a predictor.
`timescale 1ns / 1ps
module pair_distance_histogram_tb;
    import pdh_pkg::*;

    localparam int NBINS    = 256;
    localparam int IW       = $clog2(NBINS);
    localparam int SETTLE   = 120;   // idle cycles after the last expected result
    localparam int RAND_PER = 215;   // random items per configuration block

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ax, ay, az, bx, by, bz;
        logic        same;
        logic [7:0]  idx;
    } t_pair_item;

    typedef struct packed {
        logic        counted;
        logic [7:0]  bin;
        logic [31:0] value;
        logic [31:0] samples;
    } t_bin_result;

    typedef struct packed {
        t_pair_item  item;
        logic        known;
        t_bin_result res;
    } t_dir_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [207:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         m_axis_tuser;

    pair_distance_histogram #(.BIN_COUNT(NBINS)) dut (.*);

    // predictor state
    logic [31:0] hist_model [NBINS];
    logic [31:0] sample_count;
    logic [31:0] box_x, box_y, box_z, max_dist, bin_w;

    t_bin_result expected_bins [$];
    int          errors;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          n_sent;
    int          n_counted;
    int          n_checked;

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    initial begin
        #1600000;
        $display("%0t timeout", $realtime);
        $display("FAIL pair_distance_histogram");
        $finish;
    end

    // minimum image with a single wrap
    function automatic logic [31:0] wrap_mag(logic [31:0] a, logic [31:0] b, logic [31:0] len);
        logic [32:0] m;
        m = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
        if ((m << 1) > {1'b0, len})
            m = (m >= {1'b0, len}) ? m - {1'b0, len} : {1'b0, len} - m;
        return m[31:0];
    endfunction

    // bit-pair integer square root of the 68-bit squared distance
    function automatic void isqrt68(input logic [67:0] v, output logic [71:0] root,
                                    output logic [71:0] rem);
        logic [71:0] trial;
        root = '0;
        rem  = '0;
        for (int i = 33; i >= 0; i--) begin
            rem   = (rem << 2) | 72'(v[2*i +: 2]);
            trial = (root << 2) | 72'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 72'd1;
            end else begin
                root = root << 1;
            end
        end
    endfunction

    // advance the predicted histogram by one item and return its result
    function automatic t_bin_result predict_bin(t_pair_item it);
        t_bin_result r;
        logic [31:0] mx, my, mz;
        logic [67:0] sum;
        logic [71:0] root, rem, bin;
        r = '0;
        case (it.op)
            OP_ACCUM: begin
                if (!it.same) begin
                    mx  = wrap_mag(it.ax, it.bx, box_x);
                    my  = wrap_mag(it.ay, it.by, box_y);
                    mz  = wrap_mag(it.az, it.bz, box_z);
                    sum = 68'(64'(mx) * 64'(mx)) + 68'(64'(my) * 64'(my))
                        + 68'(64'(mz) * 64'(mz));
                    isqrt68(sum, root, rem);
                    if (!(root > 72'(max_dist) || (root == 72'(max_dist) && rem != 0))) begin
                        bin = (bin_w == 0) ? 72'(NBINS - 1) : root / 72'(bin_w);
                        if (bin > 72'(NBINS - 1)) bin = 72'(NBINS - 1);
                        if (hist_model[bin[IW-1:0]] != 32'hFFFF_FFFF)
                            hist_model[bin[IW-1:0]]++;
                        r.counted = 1'b1;
                        r.bin     = bin[7:0];
                        r.value   = hist_model[bin[IW-1:0]];
                    end
                end
            end
            OP_END: if (sample_count != 32'hFFFF_FFFF) sample_count++;
            OP_READ: begin
                r.bin = it.idx;
                if (32'(it.idx) < NBINS) r.value = hist_model[IW'(it.idx)];
            end
            default: ;
        endcase
        r.samples = sample_count;
        return r;
    endfunction

    // one transfer on the input stream; predicts at acceptance
    task automatic send_item(t_pair_item it, logic known, t_bin_result res);
        t_bin_result p;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, it.idx, it.bz, it.by, it.bx, it.az, it.ay, it.ax, it.op};
        s_axis_tuser  <= it.same;
        do @(posedge i_clk); while (!s_axis_tready);
        p = predict_bin(it);
        expected_bins.push_back(known ? res : p);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_bins.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // one register transfer; the caller drops valid after the last write
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_BOX_X: box_x    = val;
            REG_BOX_Y: box_y    = val;
            REG_BOX_Z: box_z    = val;
            REG_MAX:   max_dist = val;
            REG_BIN_W: bin_w    = val;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // coordinate near base: a signed offset up to the reach
    function automatic logic [31:0] nearby(logic [31:0] base, logic [31:0] reach);
        logic [31:0] d;
        d = $urandom_range(reach, 0);
        return $urandom_range(1) ? base + d : base - d;
    endfunction

    // random item, mostly pairs close enough to be counted
    function automatic t_pair_item rand_item();
        t_pair_item  it;
        logic [31:0] reach;
        int          pick;
        reach   = (max_dist == 0) ? 32'd2 : (max_dist >> 1);
        pick    = $urandom_range(99);
        it.op   = OP_ACCUM;
        it.ax   = $urandom; it.ay = $urandom; it.az = $urandom;
        it.bx   = $urandom; it.by = $urandom; it.bz = $urandom;
        it.same = ($urandom_range(19) == 0);
        it.idx  = 8'($urandom);
        if (pick < 50) begin
            it.ax = it.ax % box_x; it.ay = it.ay % box_y; it.az = it.az % box_z;
            it.bx = nearby(it.ax, reach);
            it.by = nearby(it.ay, reach);
            it.bz = nearby(it.az, reach);
        end else if (pick < 70) begin
            // across the periodic boundary
            it.ax = it.ax % box_x; it.ay = it.ay % box_y; it.az = it.az % box_z;
            it.bx = nearby(it.ax + box_x, reach);
            it.by = nearby(it.ay, reach);
            it.bz = nearby(it.az - box_z, reach);
        end else if (pick < 80) begin
            it.same = 1'($urandom);
        end else if (pick < 90) begin
            it.op = OP_END;
        end else if (pick < 97) begin
            it.op = OP_READ;
        end else begin
            it.op = 2'd3;
        end
        return it;
    endfunction

    // result check against the oldest expectation
    always @(posedge i_clk) begin
        t_bin_result e, a;
        if (m_axis_tvalid && m_axis_tready) begin
            a = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[39:8], m_axis_tdata[71:40]};
            if (expected_bins.size() == 0) begin
                $display("%0t unexpected result %h", $realtime, a);
                errors++;
            end else begin
                e = expected_bins.pop_front();
                n_checked++;
                if (a.counted) n_counted++;
                if (a.counted !== e.counted) begin
                    $display("%0t counted exp %b got %b", $realtime, e.counted, a.counted);
                    errors++;
                end
                if (a.bin !== e.bin) begin
                    $display("%0t bin_hit exp %h got %h", $realtime, e.bin, a.bin);
                    errors++;
                end
                if (a.value !== e.value) begin
                    $display("%0t bin_value exp %h got %h", $realtime, e.value, a.value);
                    errors++;
                end
                if (a.samples !== e.samples) begin
                    $display("%0t samples_taken exp %h got %h", $realtime, e.samples, a.samples);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    // directed rows under the reset configuration
    t_dir_row dir_rows [21] = '{
        '{'{OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1, '{1'b0, 8'h00, 0, 0}},
        '{'{OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 8'hFF}, 1'b1, '{1'b0, 8'hFF, 0, 0}},
        '{'{2'd3, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1, '{1'b0, 8'h00, 0, 0}},
        '{'{OP_END, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1, '{1'b0, 8'h00, 0, 1}},
        '{'{OP_ACCUM, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1, '{1'b1, 8'h00, 1, 1}},
        '{'{OP_ACCUM, 0, 0, 0, 0, 0, 0, 1'b1, 8'h00}, 1'b1, '{1'b0, 8'h00, 0, 1}},
        '{'{OP_ACCUM, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 1'b0, 8'h00}, 1'b1,
          '{1'b1, 8'h00, 2, 1}},
        '{'{OP_ACCUM, 32'h100, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1, '{1'b1, 8'h01, 1, 1}},
        // distance exactly at the limit lands past the last bin and clamps
        '{'{OP_ACCUM, 32'h1_0000, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1,
          '{1'b1, 8'hFF, 1, 1}},
        '{'{OP_ACCUM, 32'h1_0001, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b1, '{1'b0, 8'h00, 0, 1}},
        '{'{OP_ACCUM, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_ACCUM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1'b0, 8'h00},
          1'b0, '0},
        '{'{OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_ACCUM, 32'h8000_0000, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_END, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 8'h01}, 1'b0, '0},
        '{'{OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 8'hFF}, 1'b0, '0},
        '{'{OP_READ, 0, 0, 0, 0, 0, 0, 1'b0, 8'h80}, 1'b0, '0},
        '{'{2'd3, '1, '1, '1, '1, '1, '1, 1'b1, 8'hFF}, 1'b0, '0},
        '{'{OP_READ, '1, '1, '1, '1, '1, '1, 1'b1, 8'hAA}, 1'b0, '0}
    };

    // configurations: box x, y, z, max distance, bin width
    logic [31:0] cfg_sets [6][5] = '{
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0004_0000, 32'h0000_0400},
        '{32'h000A_0000, 32'h000A_0000, 32'h000A_0000, 32'hFFFF_FFFF, 32'h0000_1000},
        '{32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001},
        '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_FFFF},
        '{32'hFFFF_FFFF, 32'h1234_5678, 32'h0010_0000, 32'h00FF_FFFF, 32'h0000_0001},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0080_0000}
    };

    initial begin
        errors        = 0;
        n_sent        = 0;
        n_counted     = 0;
        n_checked     = 0;
        tx_idle_pct   = 6;
        rx_idle_pct   = 64;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        foreach (hist_model[i]) hist_model[i] = '0;
        sample_count = '0;
        box_x = '1; box_y = '1; box_z = '1;
        max_dist = 32'h1_0000;
        bin_w    = 32'h100;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].known, dir_rows[r].res);

        for (int blk = 0; blk < 6; blk++) begin
            drain();
            if (blk == 2) begin
                tx_idle_pct = 64; rx_idle_pct = 6;
            end else if (blk == 4) begin
                tx_idle_pct = 0;  rx_idle_pct = 0;
            end
            write_reg(REG_BOX_X, cfg_sets[blk][0]);
            write_reg(REG_BOX_Y, cfg_sets[blk][1]);
            write_reg(REG_BOX_Z, cfg_sets[blk][2]);
            write_reg(REG_MAX,   cfg_sets[blk][3]);
            write_reg(REG_BIN_W, cfg_sets[blk][4]);
            i_cfg_valid <= 1'b0;
            for (int n = 0; n < RAND_PER; n++) send_item(rand_item(), 1'b0, '0);
        end
        drain();

        $display("Sent %0d items over 6 box/limit/bin settings and 3 idling patterns;", n_sent);
        $display("checked %0d results, %0d of them counted pairs.", n_checked, n_counted);
        if (errors == 0) begin
            $display("PASS pair_distance_histogram");
        end else begin
            $display("FAIL pair_distance_histogram");
        end
        $finish;
    end

endmodule

>>> pair_distance_histogram.f
src/pdh_pkg.sv
src/pair_distance_histogram.sv
bench/pair_distance_histogram_tb.sv
